// ===== rtl/core/indexed_linked_list_store_unit_defines.svh =====
// Assertion macros for the indexed linked list store unit.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef INDEXED_LINKED_LIST_STORE_UNIT_DEFINES_SVH
`define INDEXED_LINKED_LIST_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define ILLS_AP_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ILLS_AP_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ills_pkg.sv =====
// Shared types and codes for the indexed linked list store unit.
// No dependencies; imported by the top level, the slot RAM users and the checker.
`default_nettype none

package ills_pkg;

    // Default sizing
    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Request codes
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_ERASE  = 2'd1;
    localparam logic [1:0] REQ_ITER   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    // Request item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] elem_value;
        logic [4:0]  position;
    } t_req;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  order_index;
        logic [31:0] out_value;
        logic        last;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/ills_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ills_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/indexed_linked_list_store_unit.sv =====
// Indexed linked list store: top level with link-walk sequencer.
// Depends on ills_pkg and ills_ram (element, next-link and prev-link stores).
//
// Usage
//   Request channel: present i_req and raise start; the item is taken at a
//   rising edge with start high and busy low. busy stays high while the
//   request is worked on.
//   Result channel: each result sits on o_rsp for one cycle with o_strobe
//   high; the receiver cannot stall, so results must be taken as they come.
// Sequence (acceptance to result strobe)
//   push, fresh slot: S_P_LINK, S_P_TAIL; push, recycled slot: S_P_FH first.
//   erase: S_E_WALK to the position (skipped for the head), then S_E_U1 to S_E_U3.
//   iterate: first result once the head is fetched, then one element per cycle;
//   push when full, erase out of range, empty list: answered from idle.
//   The walk follows the next-link store, one registered read per slot per
//   cycle; unlinking runs S_E_U1 to S_E_U3 with single-port writes per store.
//   A new request can be taken in the cycle the final result is shown.
// Reset
//   Synchronous, active low: the list, free chain and counters are emptied
//   at once; slot stores are not cleared and need no sweep.
`default_nettype none

module indexed_linked_list_store_unit
    import ills_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_strobe,
    output t_rsp      o_rsp
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int LINK_W = SLOT_W + 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [LINK_W-1:0] NONE_LINK = {1'b1, {SLOT_W{1'b0}}};

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_P_FH   = 4'd1;
    localparam logic [3:0] S_P_LINK = 4'd2;
    localparam logic [3:0] S_P_TAIL = 4'd3;
    localparam logic [3:0] S_E_WALK = 4'd4;
    localparam logic [3:0] S_E_U1   = 4'd5;
    localparam logic [3:0] S_E_U2   = 4'd6;
    localparam logic [3:0] S_E_U3   = 4'd7;
    localparam logic [3:0] S_I_EMIT = 4'd8;

    logic [3:0]            r_state, n_state;
    logic [LINK_W-1:0]     r_head, n_head;
    logic [LINK_W-1:0]     r_tail, n_tail;
    logic [LINK_W-1:0]     r_free, n_free;
    logic [CNT_W-1:0]      r_touched, n_touched;
    logic [CNT_W-1:0]      r_live, n_live;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [4:0]            r_cnt, n_cnt;
    logic [4:0]            r_pos, n_pos;
    logic [SLOT_W-1:0]     r_k, n_k;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic                  r_strobe, n_strobe;
    t_rsp                  r_rsp, n_rsp;

    // Slot store ports
    logic                  elem_we, elem_re;
    logic [SLOT_W-1:0]     elem_waddr, elem_raddr;
    logic [DATA_WIDTH-1:0] elem_wdata, elem_rdata;
    logic                  nxt_we, nxt_re;
    logic [SLOT_W-1:0]     nxt_waddr, nxt_raddr;
    logic [LINK_W-1:0]     nxt_wdata, nxt_rdata;
    logic                  prv_we, prv_re;
    logic [SLOT_W-1:0]     prv_waddr, prv_raddr;
    logic [LINK_W-1:0]     prv_wdata, prv_rdata;

    // Width adaption of payload words
    logic [63:0] in_value64;
    logic [63:0] out_value64;
    logic [31:0] k_ext;
    logic        iter_fin;

    assign in_value64  = 64'(i_req.elem_value);
    assign out_value64 = 64'(elem_rdata);
    assign k_ext       = 32'(r_k);
    assign iter_fin    = nxt_rdata[SLOT_W] || (r_k == SLOT_W'(CAPACITY - 1));

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // Sequencer and store control
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_free    = r_free;
        n_touched = r_touched;
        n_live    = r_live;
        n_slot    = r_slot;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_k       = r_k;
        n_value   = r_value;
        n_strobe  = 1'b0;
        n_rsp     = r_rsp;

        elem_we    = 1'b0;
        elem_waddr = r_slot;
        elem_wdata = r_value;
        elem_re    = 1'b0;
        elem_raddr = r_head[SLOT_W-1:0];
        nxt_we     = 1'b0;
        nxt_waddr  = r_slot;
        nxt_wdata  = NONE_LINK;
        nxt_re     = 1'b0;
        nxt_raddr  = r_head[SLOT_W-1:0];
        prv_we     = 1'b0;
        prv_waddr  = r_slot;
        prv_wdata  = NONE_LINK;
        prv_re     = 1'b0;
        prv_raddr  = r_head[SLOT_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_req.req_type)
                        REQ_PUSH: begin
                            n_value = in_value64[DATA_WIDTH-1:0];
                            if (!r_free[SLOT_W]) begin
                                // recycle the free-chain head
                                nxt_re    = 1'b1;
                                nxt_raddr = r_free[SLOT_W-1:0];
                                n_slot    = r_free[SLOT_W-1:0];
                                n_state   = S_P_FH;
                            end else if (r_touched < CNT_W'(CAPACITY)) begin
                                n_slot    = r_touched[SLOT_W-1:0];
                                n_touched = r_touched + CNT_W'(1);
                                n_state   = S_P_LINK;
                            end else begin
                                n_strobe = 1'b1;
                                n_rsp    = '{status: STAT_FULL, order_index: 5'd0,
                                             out_value: 32'd0, last: 1'b1};
                            end
                        end
                        REQ_ERASE: begin
                            n_pos = i_req.position;
                            if (32'(i_req.position) >= 32'(r_live)) begin
                                n_strobe = 1'b1;
                                n_rsp    = '{status: STAT_RANGE, order_index: 5'd0,
                                             out_value: 32'd0, last: 1'b1};
                            end else if (i_req.position == 5'd0) begin
                                // head is the target: fetch its links
                                nxt_re  = 1'b1;
                                prv_re  = 1'b1;
                                n_slot  = r_head[SLOT_W-1:0];
                                n_state = S_E_U1;
                            end else begin
                                nxt_re  = 1'b1;
                                n_cnt   = 5'd1;
                                n_state = S_E_WALK;
                            end
                        end
                        REQ_ITER: begin
                            if ((r_live == '0) || r_head[SLOT_W]) begin
                                n_strobe = 1'b1;
                                n_rsp    = '{status: STAT_EMPTY, order_index: 5'd0,
                                             out_value: 32'd0, last: 1'b1};
                            end else begin
                                nxt_re  = 1'b1;
                                elem_re = 1'b1;
                                n_k     = '0;
                                n_state = S_I_EMIT;
                            end
                        end
                        default: begin
                            // unused code: no result
                        end
                    endcase
                end
            end

            // Advance free chain past the recycled slot
            S_P_FH: begin
                n_free = nxt_rdata;
                if (!nxt_rdata[SLOT_W]) begin
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata[SLOT_W-1:0];
                    prv_wdata = NONE_LINK;
                end
                n_state = S_P_LINK;
            end

            // Fill the new slot
            S_P_LINK: begin
                elem_we    = 1'b1;
                nxt_we     = 1'b1;
                nxt_wdata  = NONE_LINK;
                prv_we     = 1'b1;
                prv_wdata  = r_tail;
                if (r_tail[SLOT_W]) begin
                    n_head = {1'b0, r_slot};
                end
                n_state = S_P_TAIL;
            end

            // Hook onto the old tail
            S_P_TAIL: begin
                if (!r_tail[SLOT_W]) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = r_tail[SLOT_W-1:0];
                    nxt_wdata = {1'b0, r_slot};
                end
                n_tail   = {1'b0, r_slot};
                n_live   = r_live + CNT_W'(1);
                n_strobe = 1'b1;
                n_rsp    = '{status: STAT_OK, order_index: 5'd0,
                             out_value: 32'd0, last: 1'b1};
                n_state  = S_IDLE;
            end

            // One link per cycle towards the target position
            S_E_WALK: begin
                nxt_re    = 1'b1;
                nxt_raddr = nxt_rdata[SLOT_W-1:0];
                if (r_cnt == r_pos) begin
                    prv_re    = 1'b1;
                    prv_raddr = nxt_rdata[SLOT_W-1:0];
                    n_slot    = nxt_rdata[SLOT_W-1:0];
                    n_state   = S_E_U1;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end

            // Bridge neighbours around the target
            S_E_U1: begin
                if (!prv_rdata[SLOT_W]) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_rdata[SLOT_W-1:0];
                    nxt_wdata = nxt_rdata;
                end else begin
                    n_head = nxt_rdata;
                end
                if (!nxt_rdata[SLOT_W]) begin
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata[SLOT_W-1:0];
                    prv_wdata = prv_rdata;
                end else begin
                    n_tail = prv_rdata;
                end
                n_state = S_E_U2;
            end

            // Target onto the free chain
            S_E_U2: begin
                nxt_we    = 1'b1;
                nxt_wdata = r_free;
                prv_we    = 1'b1;
                prv_wdata = NONE_LINK;
                n_state   = S_E_U3;
            end

            S_E_U3: begin
                if (!r_free[SLOT_W]) begin
                    prv_we    = 1'b1;
                    prv_waddr = r_free[SLOT_W-1:0];
                    prv_wdata = {1'b0, r_slot};
                end
                n_free   = {1'b0, r_slot};
                n_live   = r_live - CNT_W'(1);
                n_strobe = 1'b1;
                n_rsp    = '{status: STAT_OK, order_index: 5'd0,
                             out_value: 32'd0, last: 1'b1};
                n_state  = S_IDLE;
            end

            // Emit one element per cycle, fetch the next
            S_I_EMIT: begin
                n_strobe = 1'b1;
                n_rsp    = '{status: STAT_OK, order_index: k_ext[4:0],
                             out_value: out_value64[31:0], last: iter_fin};
                if (iter_fin) begin
                    n_state = S_IDLE;
                end else begin
                    nxt_re     = 1'b1;
                    nxt_raddr  = nxt_rdata[SLOT_W-1:0];
                    elem_re    = 1'b1;
                    elem_raddr = nxt_rdata[SLOT_W-1:0];
                    n_k        = r_k + SLOT_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= NONE_LINK;
            r_tail    <= NONE_LINK;
            r_free    <= NONE_LINK;
            r_touched <= '0;
            r_live    <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_free    <= n_free;
            r_touched <= n_touched;
            r_live    <= n_live;
            r_strobe  <= n_strobe;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_cnt   <= n_cnt;
        r_pos   <= n_pos;
        r_k     <= n_k;
        r_value <= n_value;
        r_rsp   <= n_rsp;
    end

    // Slot stores
    ills_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_elem (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (elem_waddr),
        .i_wdata (elem_wdata),
        .i_re    (elem_re),
        .i_raddr (elem_raddr),
        .o_rdata (elem_rdata)
    );

    ills_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_re    (nxt_re),
        .i_raddr (nxt_raddr),
        .o_rdata (nxt_rdata)
    );

    ills_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev (
        .i_clk   (i_clk),
        .i_we    (prv_we),
        .i_waddr (prv_waddr),
        .i_wdata (prv_wdata),
        .i_re    (prv_re),
        .i_raddr (prv_raddr),
        .o_rdata (prv_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ills_checker.sv =====
// Port-level checker for the indexed linked list store unit, bound to the top.
// Depends on ills_pkg and indexed_linked_list_store_unit_defines.svh.
`default_nettype none

`include "indexed_linked_list_store_unit_defines.svh"

module ills_checker
    import ills_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire t_req i_req,
    input wire logic o_strobe,
    input wire t_rsp o_rsp
);

    logic take;
    assign take = start && !busy;

    // a real request either starts work or answers at once
    `ILLS_AP_NEXT(a_req_answered, take && (i_req.req_type != REQ_UNUSED), busy || o_strobe, "request neither started nor answered")

    // unused code leaves the block idle and silent
    `ILLS_AP_NEXT(a_unused_quiet, take && (i_req.req_type == REQ_UNUSED), !busy && !o_strobe, "unused request code had an effect")

    // iterate results run back to back until the final one
    `ILLS_AP_NEXT(a_iter_burst, o_strobe && !o_rsp.last, o_strobe, "gap inside an iterate burst")

    // final result frees the block
    `ILLS_AP_NOW(a_last_idle, o_strobe && o_rsp.last, !busy, "busy while final result shown")

    // non-ok results carry no element
    `ILLS_AP_NOW(a_err_clean, o_strobe && (o_rsp.status != STAT_OK), o_rsp.last && (o_rsp.order_index == 5'd0) && (o_rsp.out_value == 32'd0), "error result with payload")

endmodule

bind indexed_linked_list_store_unit ills_checker u_ills_checker (.*);

`default_nettype wire

// ===== verif/tb_indexed_linked_list_store_unit.sv =====
// Self-checking testbench for indexed_linked_list_store_unit: push, erase and iterate
// items are checked against a behavioural list model kept in the bench.
// Depends on ills_pkg and the RTL of the block only.

module tb_indexed_linked_list_store_unit;

    import ills_pkg::*;

    localparam int         CAP        = CAPACITY_DEF;
    localparam logic [5:0] NO_SLOT    = 6'h3F;
    localparam int         IDLE_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_strobe;
    t_rsp o_rsp;

    // Behavioural copy of the list: slot stores, links, free chain, counters
    logic [31:0] list_value [CAP];
    logic [5:0]  list_next  [CAP];
    logic [5:0]  list_prev  [CAP];
    logic [5:0]  list_head;
    logic [5:0]  list_tail;
    logic [5:0]  free_head;
    int          fresh_count;
    int          live_count;

    t_rsp pending_results [$];
    int   mismatch_count = 0;
    int   idle_cycles    = 0;
    bit   no_idle        = 1'b0;

    indexed_linked_list_store_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    // Clock, period 12
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit slot_ok(input logic [5:0] s);
        return s < CAP;
    endfunction

    function automatic t_req make_req(input logic [1:0] kind, input logic [31:0] value,
                                      input logic [4:0] pos);
        t_req r;
        r.req_type   = kind;
        r.elem_value = value;
        r.position   = pos;
        return r;
    endfunction

    // Work out the results of one accepted item and update the list copy
    task automatic predict_list_request(input t_req r);
        logic [5:0] s;
        logic [5:0] p;
        logic [5:0] n;
        int         k;
        t_rsp       e;
        e        = '0;
        e.status = STAT_OK;
        e.last   = 1'b1;
        case (r.req_type)
            REQ_PUSH: begin
                s = NO_SLOT;
                if (slot_ok(free_head)) begin
                    s         = free_head;
                    free_head = list_next[s];
                    if (slot_ok(free_head))
                        list_prev[free_head] = NO_SLOT;
                end else if (fresh_count < CAP) begin
                    s = 6'(fresh_count);
                    fresh_count++;
                end else begin
                    e.status = STAT_FULL;
                end
                if (s != NO_SLOT) begin
                    if (!slot_ok(list_tail)) begin
                        list_head    = s;
                        list_prev[s] = NO_SLOT;
                    end else begin
                        list_next[list_tail] = s;
                        list_prev[s]         = list_tail;
                    end
                    list_next[s]  = NO_SLOT;
                    list_tail     = s;
                    list_value[s] = r.elem_value;
                    live_count++;
                end
                pending_results.push_back(e);
            end
            REQ_ERASE: begin
                s = list_head;
                if (r.position >= live_count) begin
                    e.status = STAT_RANGE;
                end else begin
                    for (k = 0; k < r.position && slot_ok(s); k++)
                        s = list_next[s];
                    if (!slot_ok(s)) begin
                        e.status = STAT_RANGE;
                    end else begin
                        p = list_prev[s];
                        n = list_next[s];
                        if (slot_ok(p)) list_next[p] = n;
                        else list_head = n;
                        if (slot_ok(n)) list_prev[n] = p;
                        else list_tail = p;
                        // unlinked slot goes to the front of the free chain
                        list_prev[s] = NO_SLOT;
                        list_next[s] = free_head;
                        if (slot_ok(free_head))
                            list_prev[free_head] = s;
                        free_head = s;
                        live_count--;
                    end
                end
                pending_results.push_back(e);
            end
            REQ_ITER: begin
                if (live_count == 0 || !slot_ok(list_head)) begin
                    e.status = STAT_EMPTY;
                    pending_results.push_back(e);
                end else begin
                    s = list_head;
                    k = 0;
                    while (slot_ok(s) && k < CAP) begin
                        n             = list_next[s];
                        e.status      = STAT_OK;
                        e.order_index = 5'(k);
                        e.out_value   = list_value[s];
                        e.last        = !slot_ok(n) || (k + 1 >= CAP);
                        pending_results.push_back(e);
                        k++;
                        s = n;
                    end
                end
            end
            default: ; // unused code: ignored, no result
        endcase
    endtask

    // Send one item after a random gap; start is left high after acceptance
    task automatic send_item(input t_req r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_list_request(r);
    endtask

    // Stop sending and wait until every expected result has come back
    task automatic wait_list_idle(input int settle);
        @(negedge i_clk);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic void note_mismatch(input string what, input t_rsp exp_rsp,
                                          input t_rsp got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: exp st=%0d idx=%0d val=%h last=%0b, got st=%0d idx=%0d val=%h last=%0b",
                     $time, what, exp_rsp.status, exp_rsp.order_index, exp_rsp.out_value,
                     exp_rsp.last, got.status, got.order_index, got.out_value, got.last);
    endfunction

    // Result checker: each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp exp_rsp;
        if (i_rst_n && o_strobe) begin
            got = o_rsp;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                exp_rsp = pending_results.pop_front();
                if (got.status !== exp_rsp.status || got.order_index !== exp_rsp.order_index ||
                    got.out_value !== exp_rsp.out_value || got.last !== exp_rsp.last)
                    note_mismatch("result mismatch", exp_rsp, got);
            end
        end
    end

    // Watchdog: too long without any item or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Iterate, erase and the unused code on an empty list
    task automatic test_empty_list();
        no_idle = 1'b0;
        send_item(make_req(REQ_ITER, 32'h0, 5'd0));
        send_item(make_req(REQ_ERASE, 32'h0, 5'd0));
        send_item(make_req(REQ_ERASE, 32'hFFFF_FFFF, 5'd31));
        send_item(make_req(REQ_UNUSED, 32'hFFFF_FFFF, 5'd31));
        wait_list_idle(4);
    endtask

    // Extreme data values pushed and read back
    task automatic test_push_extremes();
        no_idle = 1'b1;
        send_item(make_req(REQ_PUSH, 32'h0000_0000, 5'd0));
        send_item(make_req(REQ_PUSH, 32'hFFFF_FFFF, 5'd31));
        send_item(make_req(REQ_PUSH, 32'h5555_5555, 5'd10));
        send_item(make_req(REQ_PUSH, 32'hAAAA_AAAA, 5'd21));
        send_item(make_req(REQ_ITER, 32'h0, 5'd0));
        wait_list_idle(4);
    endtask

    // Erase out of range, in the middle, at the tail and at the head; reuse freed slots
    task automatic test_erase_cases();
        no_idle = 1'b0;
        send_item(make_req(REQ_ERASE, 32'h0, 5'd4));
        send_item(make_req(REQ_ERASE, 32'h0, 5'd1));
        send_item(make_req(REQ_ERASE, 32'h0, 5'd2));
        send_item(make_req(REQ_ERASE, 32'h0, 5'd0));
        send_item(make_req(REQ_ITER, 32'h0, 5'd0));
        send_item(make_req(REQ_PUSH, 32'h1234_5678, 5'd0));
        send_item(make_req(REQ_PUSH, 32'h9ABC_DEF0, 5'd0));
        send_item(make_req(REQ_PUSH, 32'h0F0F_F0F0, 5'd0));
        send_item(make_req(REQ_ITER, 32'h0, 5'd0));
        wait_list_idle(4);
    endtask

    // Fill to capacity, push while full, long walks, then empty the list again
    task automatic test_full_list();
        no_idle = 1'($urandom_range(0, 1));
        while (live_count < CAP)
            send_item(make_req(REQ_PUSH, $urandom, 5'($urandom)));
        send_item(make_req(REQ_PUSH, $urandom, 5'd0));
        send_item(make_req(REQ_PUSH, 32'hFFFF_FFFF, 5'd31));
        send_item(make_req(REQ_ITER, 32'h0, 5'd0));
        send_item(make_req(REQ_ERASE, 32'h0, 5'd31));
        // last free slot taken: free chain runs out
        send_item(make_req(REQ_PUSH, $urandom, 5'd0));
        send_item(make_req(REQ_PUSH, $urandom, 5'd0));
        send_item(make_req(REQ_ERASE, 32'h0, 5'd16));
        send_item(make_req(REQ_ITER, 32'h0, 5'd0));
        no_idle = 1'($urandom_range(0, 1));
        while (live_count > 0)
            send_item(make_req(REQ_ERASE, $urandom, 5'($urandom_range(0, live_count - 1))));
        send_item(make_req(REQ_ITER, 32'h0, 5'd0));
        wait_list_idle(4);
    endtask

    // Mixed traffic in growing and shrinking stretches
    task automatic test_random_traffic(input int n_items);
        int         sent;
        int         stretch;
        int         roll;
        bit         growing;
        logic [1:0] kind;
        logic [4:0] pos;
        sent    = 0;
        stretch = 0;
        growing = 1'b1;
        while (sent < n_items) begin
            if (stretch == 0) begin
                stretch = $urandom_range(15, 40);
                growing = (live_count < 8) ? 1'b1 : (live_count > 26) ? 1'b0 :
                          1'($urandom_range(0, 1));
                no_idle = ($urandom_range(0, 3) == 0);
            end
            stretch--;
            roll = $urandom_range(0, 99);
            if (growing)
                kind = (roll < 55) ? REQ_PUSH : (roll < 75) ? REQ_ERASE :
                       (roll < 95) ? REQ_ITER : REQ_UNUSED;
            else
                kind = (roll < 20) ? REQ_PUSH : (roll < 70) ? REQ_ERASE :
                       (roll < 95) ? REQ_ITER : REQ_UNUSED;
            if (live_count > 0 && $urandom_range(0, 3) != 0)
                pos = 5'($urandom_range(0, live_count - 1));
            else
                pos = 5'($urandom_range(0, 31));
            send_item(make_req(kind, $urandom, pos));
            if (kind != REQ_UNUSED)
                sent++;
        end
        wait_list_idle(4);
    endtask

    // Test sequence
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        list_head   = NO_SLOT;
        list_tail   = NO_SLOT;
        free_head   = NO_SLOT;
        fresh_count = 0;
        live_count  = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_push_extremes();
        test_erase_cases();
        test_full_list();
        test_random_traffic(220);

        wait_list_idle(40);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ills_pkg.sv
rtl/core/ills_ram.sv
rtl/core/indexed_linked_list_store_unit.sv
rtl/core/ills_checker.sv
verif/tb_indexed_linked_list_store_unit.sv
